// ===== hdl/ordered_sequence_store_core_defines.svh =====
// ----------------------------------------------------------------------------
// ordered_sequence_store_core_defines.svh
// Assertion macros shared by the sequence store RTL.
// ----------------------------------------------------------------------------
`ifndef ORDERED_SEQUENCE_STORE_CORE_DEFINES_SVH
`define ORDERED_SEQUENCE_STORE_CORE_DEFINES_SVH

// same-cycle implication
`define OSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/oss_pkg.sv =====
// ----------------------------------------------------------------------------
// oss_pkg
// Widths, command codes and status codes of the ordered sequence store.
// ----------------------------------------------------------------------------
`default_nettype none

package oss_pkg;

  localparam int CMD_W  = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 7;
  localparam int STAT_W = 3;

  localparam int DEFAULT_DEPTH      = 64;
  localparam int DEFAULT_DATA_WIDTH = 32;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_REAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd6;
  localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_INVALID   = 3'd3;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd5;

endpackage

`default_nettype wire

// ===== hdl/oss_in_if.sv =====
// ----------------------------------------------------------------------------
// oss_in_if
// Command channel: one beat carries command, value and position.
// ----------------------------------------------------------------------------
`default_nettype none

interface oss_in_if;
  import oss_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source (output valid, command, value, position, input ready);
  modport sink   (input valid, command, value, position, output ready);
endinterface

`default_nettype wire

// ===== hdl/oss_out_if.sv =====
// ----------------------------------------------------------------------------
// oss_out_if
// Result channel: one beat carries status, data and last.
// ----------------------------------------------------------------------------
`default_nettype none

interface oss_out_if;
  import oss_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] data;
  logic                    last;

  modport source (output valid, status, data, last, input ready);
  modport sink   (input valid, status, data, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/oss_store.sv =====
// ----------------------------------------------------------------------------
// oss_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module oss_store #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [DATA_WIDTH-1:0]                  wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [DATA_WIDTH-1:0]                  rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ordered_sequence_store_core.sv =====
// ----------------------------------------------------------------------------
// ordered_sequence_store_core
// Bounded ordered sequence of signed words with positional insert/delete,
// key search and dump, run by a small sequencer over one memory port pair.
//
//   channel   dir   beat
//   in_ch     in    command, value, position
//   out_ch    out   status, data, last
//
// After accept: insert at index k shifts entries k..length-1 up, then writes
// the word; delete at k reads the entry, then shifts later entries down;
// search compares entries in order until a match or the end. These and
// status-only answers end in the result state; dump emits a beat per entry
// read. Reset clears state, length and out valid; no entry is read unwritten.
// in_ch.ready is high only when idle; a stalled out_ch holds the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_sequence_store_core_defines.svh"

module ordered_sequence_store_core #(
  parameter int DEPTH      = oss_pkg::DEFAULT_DEPTH,
  parameter int DATA_WIDTH = oss_pkg::DEFAULT_DATA_WIDTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  oss_in_if.sink    in_ch,
  oss_out_if.source out_ch
);
  import oss_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = (LW > POS_W) ? LW : POS_W;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_INS_RD    = 4'd1;
  localparam logic [3:0] S_INS_WR    = 4'd2;
  localparam logic [3:0] S_INS_PUT   = 4'd3;
  localparam logic [3:0] S_DEL_RD    = 4'd4;
  localparam logic [3:0] S_DEL_CAP   = 4'd5;
  localparam logic [3:0] S_DSH_RD    = 4'd6;
  localparam logic [3:0] S_DSH_WR    = 4'd7;
  localparam logic [3:0] S_SCAN_RD   = 4'd8;
  localparam logic [3:0] S_SCAN_CHK  = 4'd9;
  localparam logic [3:0] S_DUMP_RD   = 4'd10;
  localparam logic [3:0] S_DUMP_EMIT = 4'd11;
  localparam logic [3:0] S_RESP      = 4'd12;

  logic [3:0]            state_r, state_nxt;
  logic [LW-1:0]         len_r, len_nxt;
  logic [LW-1:0]         ptr_r, ptr_nxt;
  logic [LW-1:0]         tgt_r, tgt_nxt;
  logic [DATA_WIDTH-1:0] word_r, word_nxt;
  logic [STAT_W-1:0]     resp_status_r, resp_status_nxt;
  logic [VAL_W-1:0]      resp_data_r, resp_data_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]     out_status_r, out_status_nxt;
  logic [VAL_W-1:0]      out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  logic                  in_fire, emit_ok;
  logic [LW-1:0]         ptr_dec, ptr_inc;
  logic [CW-1:0]         pos_ext, len_ext, pos_m1;
  logic                  pos_le1;

  oss_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign emit_ok       = !out_valid_r || out_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.data   = out_data_r;
  assign out_ch.last   = out_last_r;

  assign ptr_dec = ptr_r - LW'(1);
  assign ptr_inc = ptr_r + LW'(1);
  assign pos_ext = CW'(in_ch.position);
  assign len_ext = CW'(len_r);
  assign pos_m1  = pos_ext - CW'(1);
  assign pos_le1 = (in_ch.position <= POS_W'(1));

  always_comb begin
    state_nxt       = state_r;
    len_nxt         = len_r;
    ptr_nxt         = ptr_r;
    tgt_nxt         = tgt_r;
    word_nxt        = word_r;
    resp_status_nxt = resp_status_r;
    resp_data_nxt   = resp_data_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_data_nxt    = out_data_r;
    out_last_nxt    = out_last_r;
    mem_we          = 1'b0;
    mem_waddr       = ptr_r[AW-1:0];
    mem_wdata       = mem_rdata;
    mem_re          = 1'b0;
    mem_raddr       = ptr_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          word_nxt      = DATA_WIDTH'(in_ch.value);
          resp_data_nxt = '0;
          state_nxt     = S_RESP;
          case (in_ch.command)
            CMD_INS_FRONT, CMD_INS_REAR, CMD_INS_POS: begin
              if (len_r == LW'(DEPTH)) begin
                resp_status_nxt = ST_FULL;
              end else begin
                if (in_ch.command == CMD_INS_FRONT) begin
                  tgt_nxt = '0;
                end else if (in_ch.command == CMD_INS_REAR) begin
                  tgt_nxt = len_r;
                end else if (pos_le1 || len_r == '0) begin
                  tgt_nxt = '0;
                end else if (pos_m1 > len_ext) begin
                  tgt_nxt = len_r;
                end else begin
                  tgt_nxt = LW'(pos_m1);
                end
                ptr_nxt   = len_r;
                state_nxt = (tgt_nxt == len_r) ? S_INS_PUT : S_INS_RD;
              end
            end
            CMD_DEL_FRONT, CMD_DEL_REAR, CMD_DEL_POS: begin
              if (len_r == '0) begin
                resp_status_nxt = ST_EMPTY;
              end else if (in_ch.command == CMD_DEL_FRONT) begin
                ptr_nxt   = '0;
                state_nxt = S_DEL_RD;
              end else if (in_ch.command == CMD_DEL_REAR) begin
                ptr_nxt   = len_r - LW'(1);
                state_nxt = S_DEL_RD;
              end else if (pos_le1) begin
                ptr_nxt   = '0;
                state_nxt = S_DEL_RD;
              end else if (pos_ext > len_ext) begin
                resp_status_nxt = ST_INVALID;
              end else begin
                ptr_nxt   = LW'(pos_m1);
                state_nxt = S_DEL_RD;
              end
            end
            CMD_SEARCH: begin
              if (len_r == '0) begin
                resp_status_nxt = ST_NOT_FOUND;
              end else begin
                ptr_nxt   = '0;
                state_nxt = S_SCAN_RD;
              end
            end
            default: begin
              if (len_r == '0) begin
                resp_status_nxt = ST_EMPTY;
              end else begin
                ptr_nxt   = '0;
                state_nxt = S_DUMP_RD;
              end
            end
          endcase
        end
      end
      S_INS_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_dec[AW-1:0];
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[AW-1:0];
        mem_wdata = mem_rdata;
        ptr_nxt   = ptr_dec;
        state_nxt = (ptr_dec == tgt_r) ? S_INS_PUT : S_INS_RD;
      end
      S_INS_PUT: begin
        mem_we          = 1'b1;
        mem_waddr       = tgt_r[AW-1:0];
        mem_wdata       = word_r;
        len_nxt         = len_r + LW'(1);
        resp_status_nxt = ST_OK;
        state_nxt       = S_RESP;
      end
      S_DEL_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        resp_data_nxt = VAL_W'(mem_rdata);
        state_nxt     = S_DSH_RD;
      end
      S_DSH_RD: begin
        if (ptr_inc < len_r) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_inc[AW-1:0];
          state_nxt = S_DSH_WR;
        end else begin
          len_nxt         = len_r - LW'(1);
          resp_status_nxt = ST_OK;
          state_nxt       = S_RESP;
        end
      end
      S_DSH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[AW-1:0];
        mem_wdata = mem_rdata;
        ptr_nxt   = ptr_inc;
        state_nxt = S_DSH_RD;
      end
      S_SCAN_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (mem_rdata == word_r) begin
          resp_status_nxt = ST_FOUND;
          state_nxt       = S_RESP;
        end else if (ptr_inc == len_r) begin
          resp_status_nxt = ST_NOT_FOUND;
          state_nxt       = S_RESP;
        end else begin
          ptr_nxt   = ptr_inc;
          state_nxt = S_SCAN_RD;
        end
      end
      S_DUMP_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_DUMP_EMIT;
      end
      S_DUMP_EMIT: begin
        if (emit_ok) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_data_nxt   = VAL_W'(mem_rdata);
          out_last_nxt   = (ptr_inc == len_r);
          ptr_nxt        = ptr_inc;
          state_nxt      = (ptr_inc == len_r) ? S_IDLE : S_DUMP_RD;
        end
      end
      S_RESP: begin
        if (emit_ok) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = resp_status_r;
          out_data_nxt   = resp_data_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r         <= ptr_nxt;
    tgt_r         <= tgt_nxt;
    word_r        <= word_nxt;
    resp_status_r <= resp_status_nxt;
    resp_data_r   <= resp_data_nxt;
    out_status_r  <= out_status_nxt;
    out_data_r    <= out_data_nxt;
    out_last_r    <= out_last_nxt;
  end

  `OSS_ASSERT_NOW(a_len_bound, clk, rst_n, 1'b1, len_r <= LW'(DEPTH), "length exceeds depth")
  `OSS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ch.ready, "ready after accept")
  `OSS_ASSERT_NEXT(a_len_step, clk, rst_n, 1'b1, (len_r == $past(len_r)) || (len_r == $past(len_r) + LW'(1)) || (len_r + LW'(1) == $past(len_r)), "length moved by more than one")

endmodule

`default_nettype wire
